// ===== src/bgra_to_yuv420_converter_unit_assert.svh =====
// Assertion macros for the BGRA to YUV 4:2:0 converter.
// No dependencies; included by the top level only.
`ifndef BGRA_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH
`define BGRA_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH

// Plain property check, sampled on the rising clock, off during reset.
`define B2Y_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
    else $error(msg);

// Same-cycle implication: when ante holds, cons must hold.
`define B2Y_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/b2y420_pkg.sv =====
// Shared types and constants for the BGRA to YUV 4:2:0 converter.
// No dependencies; imported by every module of the block.
package b2y420_pkg;

  localparam int COLOR_W = 8;
  localparam int SUM_W   = 9;               // sum of two 8-bit samples
  localparam int PSUM_W  = 3 * SUM_W;       // packed B | G<<9 | R<<18 pair sums
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // BT.601 full-range luma weights
  localparam logic [7:0] Y_R_COEF = 8'd77;
  localparam logic [7:0] Y_G_COEF = 8'd150;
  localparam logic [7:0] Y_B_COEF = 8'd29;
  localparam logic [7:0] ROUND_HALF = 8'd128;

  // Chroma weights
  localparam logic signed [8:0] U_R_COEF = -9'sd43;
  localparam logic signed [8:0] U_G_COEF = -9'sd85;
  localparam logic signed [8:0] U_B_COEF = 9'sd128;
  localparam logic signed [8:0] V_R_COEF = 9'sd128;
  localparam logic signed [8:0] V_G_COEF = -9'sd107;
  localparam logic signed [8:0] V_B_COEF = -9'sd21;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] luma;
    logic               chroma_valid;
    logic [COLOR_W-1:0] chroma_blue_diff;
    logic [COLOR_W-1:0] chroma_red_diff;
    logic               line_end;
    logic               frame_end;
  } out_item_t;

  // First pipeline stage: pixel, pair sums and position flags
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [SUM_W-1:0]   sum_b;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_r;
    logic               chroma_cand;   // block completes at this pixel
    logic               from_store;    // other row's sums come from the line store
    logic               line_end;
    logic               frame_end;
  } s1_item_t;

  // Line store access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== src/b2y420_line_mem.sv =====
// Line store: one-port-write, one-port-read synchronous RAM of pair sums.
// Depends on b2y420_pkg for the entry width.
module b2y420_line_mem
  import b2y420_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [PSUM_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [PSUM_W-1:0] rd_data
);

  logic [PSUM_W-1:0] mem [DEPTH];
  logic [PSUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/b2y420_seq.sv =====
// Raster position tracker, config registers and line store addressing.
// Depends on b2y420_pkg; feeds the first pipeline stage.
module b2y420_seq
  import b2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  input  in_item_t              in_data,
  input  logic                  adv,
  output mem_ctl_t              mem_ctl,
  output logic [$clog2(MAX_WIDTH/2)-1:0] mem_addr,
  output logic [PSUM_W-1:0]     mem_wr_data,
  output logic                  s1_vld,
  output s1_item_t              s1_item
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int IW    = $clog2(DEPTH);
  localparam int XW    = CFG_DATA_W + 1;

  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [CW-1:0]         col_r, col_nxt, col_cur, last_col;
  logic [RW-1:0]         row_r, row_nxt, row_cur, last_row;
  logic [COLOR_W-1:0]    prev_b_r, prev_g_r, prev_r_r;
  logic                  s1_vld_r;
  s1_item_t              s1_r, s1_nxt;
  logic                  accept, lend, last_line, fend;
  logic [CW-2:0]         idx_full;

  assign accept = in_valid & adv;

  // Out-of-range sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) begin
      last_col = '0;
    end else if ({1'b0, width_r} > XW'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      last_row = '0;
    end else if ({1'b0, height_r} > XW'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(height_r - 1'b1);
    end
  end

  assign col_cur   = in_data.frame_start ? '0 : col_r;
  assign row_cur   = in_data.frame_start ? '0 : row_r;
  assign lend      = col_cur >= last_col;
  assign last_line = row_cur >= last_row;
  assign fend      = lend & last_line;

  assign idx_full = col_cur[CW-1:1];
  assign mem_addr = (idx_full > (CW-1)'(DEPTH - 1)) ? IW'(DEPTH - 1) : IW'(idx_full);

  always_comb begin
    s1_nxt.blue        = in_data.blue;
    s1_nxt.green       = in_data.green;
    s1_nxt.red         = in_data.red;
    s1_nxt.sum_b       = {1'b0, prev_b_r} + {1'b0, in_data.blue};
    s1_nxt.sum_g       = {1'b0, prev_g_r} + {1'b0, in_data.green};
    s1_nxt.sum_r       = {1'b0, prev_r_r} + {1'b0, in_data.red};
    s1_nxt.chroma_cand = col_cur[0] & (row_cur[0] | last_line);
    s1_nxt.from_store  = row_cur[0];
    s1_nxt.line_end    = lend;
    s1_nxt.frame_end   = fend;
  end

  // Even row writes, odd row reads: a pair's entry is always written a full line ahead
  assign mem_ctl.wr_en = accept & col_cur[0] & ~row_cur[0] & ~last_line;
  assign mem_ctl.rd_en = accept & col_cur[0] & row_cur[0];
  assign mem_wr_data   = {s1_nxt.sum_r, s1_nxt.sum_g, s1_nxt.sum_b};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (lend) begin
        col_nxt = '0;
        row_nxt = fend ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      prev_b_r <= '0;
      prev_g_r <= '0;
      prev_r_r <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_wr_data;
          CFG_FRAME_HEIGHT: height_r <= cfg_wr_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        prev_b_r <= in_data.blue;
        prev_g_r <= in_data.green;
        prev_r_r <= in_data.red;
      end
      if (adv) begin
        s1_vld_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_item = s1_r;

endmodule

// ===== src/b2y420_csc.sv =====
// Color math: luma and 2x2 averages, then U/V with clamping into the output register.
// Depends on b2y420_pkg; takes the first stage and line store read data.
module b2y420_csc
  import b2y420_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              s1_vld,
  input  s1_item_t          s1_item,
  input  logic [PSUM_W-1:0] mem_rd_data,
  output logic              out_valid,
  output out_item_t         out_data
);

  function automatic logic signed [18:0] mul_k(input logic [7:0] a,
                                               input logic signed [8:0] k);
    logic signed [18:0] ae;
    logic signed [18:0] ke;
    ae = {11'b0, a};
    ke = {{10{k[8]}}, k};
    return ae * ke;
  endfunction

  // floor(t / 256) + 128, clamped to a byte
  function automatic logic [7:0] chroma_clamp(input logic signed [18:0] t);
    logic signed [10:0] q;
    logic signed [10:0] q_off;
    q     = t[18:8];
    q_off = q + 11'sd128;
    if (q_off < 0) begin
      return 8'd0;
    end else if (q_off > 11'sd255) begin
      return 8'd255;
    end else begin
      return q_off[7:0];
    end
  endfunction

  logic                s2_vld_r;
  logic [COLOR_W-1:0]  luma_r, avg_b_r, avg_g_r, avg_r_r;
  logic                chroma_r, lend_r, fend_r;
  logic                out_valid_r;
  out_item_t           out_r, out_nxt;

  logic [15:0]         luma_acc;
  logic [PSUM_W-1:0]   other;
  logic [SUM_W:0]      tot_b, tot_g, tot_r;
  logic signed [18:0]  t_u, t_v;

  assign luma_acc = 16'(s1_item.red)   * 16'(Y_R_COEF)
                  + 16'(s1_item.green) * 16'(Y_G_COEF)
                  + 16'(s1_item.blue)  * 16'(Y_B_COEF)
                  + 16'(ROUND_HALF);

  // Last odd row pairs with itself
  assign other = s1_item.from_store ? mem_rd_data
                                    : {s1_item.sum_r, s1_item.sum_g, s1_item.sum_b};
  assign tot_b = {1'b0, s1_item.sum_b} + {1'b0, other[SUM_W-1:0]} + (SUM_W+1)'(2);
  assign tot_g = {1'b0, s1_item.sum_g} + {1'b0, other[2*SUM_W-1:SUM_W]} + (SUM_W+1)'(2);
  assign tot_r = {1'b0, s1_item.sum_r} + {1'b0, other[3*SUM_W-1:2*SUM_W]} + (SUM_W+1)'(2);

  assign t_u = mul_k(avg_r_r, U_R_COEF) + mul_k(avg_g_r, U_G_COEF)
             + mul_k(avg_b_r, U_B_COEF) + 19'sd128;
  assign t_v = mul_k(avg_r_r, V_R_COEF) + mul_k(avg_g_r, V_G_COEF)
             + mul_k(avg_b_r, V_B_COEF) + 19'sd128;

  always_comb begin
    out_nxt.luma             = luma_r;
    out_nxt.chroma_valid     = chroma_r;
    out_nxt.chroma_blue_diff = chroma_r ? chroma_clamp(t_u) : '0;
    out_nxt.chroma_red_diff  = chroma_r ? chroma_clamp(t_v) : '0;
    out_nxt.line_end         = lend_r;
    out_nxt.frame_end        = fend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r    <= s1_vld;
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma_r   <= luma_acc[15:8];
      avg_b_r  <= tot_b[SUM_W:2];
      avg_g_r  <= tot_g[SUM_W:2];
      avg_r_r  <= tot_r[SUM_W:2];
      chroma_r <= s1_item.chroma_cand;
      lend_r   <= s1_item.line_end;
      fend_r   <= s1_item.frame_end;
      out_r    <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/bgra_to_yuv420_converter_unit.sv =====
// BGRA to YUV 4:2:0 converter (BT.601 full range), top level; uses b2y420_pkg,
// b2y420_seq, b2y420_line_mem, b2y420_csc and the assert macro header.
// An input transfer's result passes the S1, S2 and OUT registers before it shows on out_valid.
// Throughput: 1 pixel per cycle while out_stall does not hold the pipe.
// Reset (rst_n low, synchronous): pipeline empty, position 0/0, previous pixel 0,
// frame size 1920x1080; line store contents undefined, no clearing pass.
`include "bgra_to_yuv420_converter_unit_assert.svh"
module bgra_to_yuv420_converter_unit
  import b2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int IW    = $clog2(DEPTH);

  // Pipeline:
  //   S1  position, pair sums, line store access issued (write on the first
  //       row of a pair, read on the second row)
  //   S2  luma, 2x2 averages with rounding; read data arrives here
  //   OUT U/V products, clamp, output register
  // The whole pipe moves together: it advances whenever the output register
  // is empty or its result transfers this cycle.
  logic              adv;
  logic              s1_vld;
  s1_item_t          s1_item;
  mem_ctl_t          mem_ctl;
  logic [IW-1:0]     mem_addr;
  logic [PSUM_W-1:0] mem_wr_data;
  logic [PSUM_W-1:0] mem_rd_data;

  // terms for the checks
  logic              mem_rw_both;
  logic              out_held;
  logic              out_no_uv;
  logic              uv_zero;
  logic              out_fend;

  assign adv      = ~out_valid | ~out_stall;
  assign in_stall = ~adv;

  b2y420_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .adv         (adv),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .s1_vld      (s1_vld),
    .s1_item     (s1_item)
  );

  // A pair's entry is written on one row and read a whole line later, so a
  // read and a write of the same entry never meet in flight: no forwarding.
  // Read data is held until the next read, which only comes with the next
  // transfer, so it stays aligned with S1 through a stall.
  b2y420_line_mem #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_addr),
    .rd_data (mem_rd_data)
  );

  b2y420_csc u_csc (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s1_vld      (s1_vld),
    .s1_item     (s1_item),
    .mem_rd_data (mem_rd_data),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // Checks
  assign mem_rw_both = mem_ctl.wr_en & mem_ctl.rd_en;
  assign out_held    = out_valid & out_stall;
  assign out_no_uv   = out_valid & ~out_data.chroma_valid;
  assign uv_zero     = (out_data.chroma_blue_diff == '0) & (out_data.chroma_red_diff == '0);
  assign out_fend    = out_valid & out_data.frame_end;

  `B2Y_ASSERT(a_rw_exclusive, clk, rst_n, !mem_rw_both, "line store read and write together")
  `B2Y_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_held, "stall without waiting result")
  `B2Y_ASSERT_IMPL(a_chroma_zero, clk, rst_n, out_no_uv, uv_zero, "U/V set without chroma_valid")
  `B2Y_ASSERT_IMPL(a_fend_lend, clk, rst_n, out_fend, out_data.line_end, "no line_end at frame_end")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bgra_to_yuv420_converter_unit: raster pixel frames under random
// stalls, every luma/chroma result checked against an in-bench predictor.
// Needs b2y420_pkg and the converter RTL.
module tb
  import b2y420_pkg::*;
();

  localparam int FRAME_MAX     = 4096;
  localparam int LINE_PAIRS    = FRAME_MAX / 2;
  localparam int DRAIN_CYCLES  = 4;       // extra wait after the last expected result, lets the pipe empty
  localparam int HOLD_CYCLES   = 60;      // long receiver hold-off, fills the pipeline
  localparam int PIXEL_TARGET  = 900;     // pixels sent by run phases before wind-down
  localparam int CYCLE_LIMIT   = 300000;

  // Predictor plus queue of expected results, one entry per accepted pixel.
  class yuv420_scoreboard;
    logic [PSUM_W-1:0] pair_sums [LINE_PAIRS];
    bit                pair_written [LINE_PAIRS];
    logic [7:0]        last_b, last_g, last_r;
    int                col, row;
    int                width_reg, height_reg;
    out_item_t         expected_pixels [$];
    int                errors;

    function new();
      foreach (pair_written[i]) pair_written[i] = 1'b0;
      last_b = '0;
      last_g = '0;
      last_r = '0;
      col = 0;
      row = 0;
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == CFG_FRAME_WIDTH) width_reg = value;
      else if (index == CFG_FRAME_HEIGHT) height_reg = value;
    endfunction

    // 0 acts as 1, oversize acts as the maximum
    function int frame_dim(int v);
      return (v < 1) ? 1 : ((v > FRAME_MAX) ? FRAME_MAX : v);
    endfunction

    function int pair_index(int c);
      return (c / 2 < LINE_PAIRS) ? c / 2 : LINE_PAIRS - 1;
    endfunction

    // Flooring shift, +128 offset, clamp to a byte
    function logic [7:0] chroma_level(int t);
      int v;
      v = (t >>> 8) + 128;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    endfunction

    // True when the next pixel would read a line-store entry never written since reset
    function bit reads_unwritten(bit frame_start);
      int c, r;
      c = frame_start ? 0 : col;
      r = frame_start ? 0 : row;
      return (c % 2 == 1) && (r % 2 == 1) && !pair_written[pair_index(c)];
    endfunction

    function void note_pixel(in_item_t px);
      int w, h, c, r, lum, sb, sg, sr, ab, ag, ar, idx;
      bit lend, fend, emit;
      logic [PSUM_W-1:0] other;
      out_item_t res;
      if (px.frame_start) begin
        col = 0;
        row = 0;
      end
      w = frame_dim(width_reg);
      h = frame_dim(height_reg);
      c = col;
      r = row;
      lend = (c >= w - 1);
      fend = lend && (r >= h - 1);
      res = '0;
      lum = (int'(Y_R_COEF) * int'(px.red) + int'(Y_G_COEF) * int'(px.green) +
             int'(Y_B_COEF) * int'(px.blue) + int'(ROUND_HALF)) >> 8;
      res.luma = lum[7:0];
      if (c % 2 == 1) begin
        sb = int'(last_b) + int'(px.blue);
        sg = int'(last_g) + int'(px.green);
        sr = int'(last_r) + int'(px.red);
        idx = pair_index(c);
        emit = 1'b1;
        other = '0;
        if (r % 2 == 1) begin
          other = pair_sums[idx];
        end else if (r >= h - 1) begin
          // odd last row pairs with itself
          other = {sr[8:0], sg[8:0], sb[8:0]};
        end else begin
          pair_sums[idx] = {sr[8:0], sg[8:0], sb[8:0]};
          pair_written[idx] = 1'b1;
          emit = 1'b0;
        end
        if (emit) begin
          ab = (sb + int'(other[8:0]) + 2) >> 2;
          ag = (sg + int'(other[17:9]) + 2) >> 2;
          ar = (sr + int'(other[26:18]) + 2) >> 2;
          res.chroma_valid = 1'b1;
          res.chroma_blue_diff = chroma_level(int'(U_R_COEF) * ar + int'(U_G_COEF) * ag +
                                              int'(U_B_COEF) * ab + int'(ROUND_HALF));
          res.chroma_red_diff = chroma_level(int'(V_R_COEF) * ar + int'(V_G_COEF) * ag +
                                             int'(V_B_COEF) * ab + int'(ROUND_HALF));
        end
      end
      last_b = px.blue;
      last_g = px.green;
      last_r = px.red;
      if (lend) begin
        col = 0;
        row = fend ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
      res.line_end = lend;
      res.frame_end = fend;
      expected_pixels.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("result transfer with nothing expected (luma %0d)", got.luma);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("luma", want.luma, got.luma);
      compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
      compare_field("chroma_blue_diff", want.chroma_blue_diff, got.chroma_blue_diff);
      compare_field("chroma_red_diff", want.chroma_red_diff, got.chroma_red_diff);
      compare_field("line_end", want.line_end, got.line_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  bit send_gaps_off = 1'b0;   // sender offers back to back
  bit sink_gaps_off = 1'b0;   // receiver never stalls on its own
  bit hold_pending  = 1'b0;   // receiver takes one long hold-off at its next transfer
  int cycle_count   = 0;
  int pixels_sent   = 0;

  yuv420_scoreboard board = new();

  bgra_to_yuv420_converter_unit #(
    .MAX_WIDTH (FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor: a transfer is valid high with stall low at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_pixel(out_data);
  end

  // Receiver: draws a random stall before each transfer, or one long hold-off on request
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = sink_gaps_off ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One pixel transfer. valid only drops when a gap is drawn, so back-to-back
  // transfers keep it high without a second assignment in the same step.
  task automatic send_pixel(in_item_t px);
    int gap;
    gap = send_gaps_off ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_pixel(px);
  endtask

  // Mostly well-formed frames: frame_start at the wrap point, rarely mid-frame.
  // Forced high where the pixel would otherwise read a line-store entry never written.
  task automatic send_random_pixel();
    in_item_t px;
    px.blue  = random_byte();
    px.green = random_byte();
    px.red   = random_byte();
    if (board.col == 0 && board.row == 0) px.frame_start = ($urandom_range(0, 7) != 0);
    else px.frame_start = ($urandom_range(0, 39) == 0);
    if (board.reads_unwritten(px.frame_start)) px.frame_start = 1'b1;
    send_pixel(px);
  endtask

  // Sender pause: wait until every expected result came back, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes, back to back; only called with the block idle
  task automatic program_frame(bit set_width, int width, bit set_height, int height);
    if (set_width) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= CFG_FRAME_WIDTH;
      cfg_wr_data <= CFG_DATA_W'(width);
      @(posedge clk);
      board.set_register(CFG_FRAME_WIDTH, CFG_DATA_W'(width));
    end
    if (set_height) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= CFG_FRAME_HEIGHT;
      cfg_wr_data <= CFG_DATA_W'(height);
      @(posedge clk);
      board.set_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(height));
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(bit set_width, int width, bit set_height, int height, int pixels);
    drain_results();
    program_frame(set_width, width, set_height, height);
    repeat (pixels) send_random_pixel();
    pixels_sent += pixels;
  endtask

  initial begin : stimulus
    in_item_t px;
    int w, h, pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 4x2 frame: a pure blue block then a pure red block, U and V clamp at the top
    program_frame(1'b1, 4, 1'b1, 2);
    for (int i = 0; i < 8; i++) begin
      px.blue  = (i % 4 < 2) ? 8'hFF : 8'h00;
      px.green = 8'h00;
      px.red   = (i % 4 < 2) ? 8'h00 : 8'hFF;
      px.frame_start = (i == 0);
      send_pixel(px);
    end

    // 5x3 frame: odd last column without chroma, odd last row paired with itself,
    // pixels walk the corners of the color cube
    drain_results();
    program_frame(1'b1, 5, 1'b1, 3);
    for (int i = 0; i < 15; i++) begin
      px.blue  = i[0] ? 8'hFF : 8'h00;
      px.green = i[1] ? 8'hFF : 8'h00;
      px.red   = i[2] ? 8'hFF : 8'h00;
      px.frame_start = (i == 0);
      send_pixel(px);
    end

    // register extremes: zero acts as one, oversize acts as the maximum
    run_phase(1'b1, 0, 1'b1, 0, 20);
    run_phase(1'b1, 8191, 1'b1, 1, 30);
    run_phase(1'b1, 4096, 1'b1, 8191, 30);

    // shrink width, then height, mid-frame: position lands past the end
    run_phase(1'b1, 7, 1'b1, 3, 40);
    run_phase(1'b1, 3, 1'b0, 0, 20);
    run_phase(1'b0, 0, 1'b1, 1, 20);

    // receiver holds off while the sender streams: pipeline fills, input stalls
    send_gaps_off = 1'b1;
    hold_pending = 1'b1;
    run_phase(1'b1, 8, 1'b1, 4, 80);
    send_gaps_off = 1'b0;

    // random frame sizes, mostly small, now and then anything the register holds
    while (pixels_sent < PIXEL_TARGET) begin
      send_gaps_off = ($urandom_range(0, 3) == 0);
      sink_gaps_off = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      w = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 8191);
      h = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 6) : $urandom_range(0, 8191);
      run_phase(pick != 8, w, pick != 9, h, $urandom_range(30, 90));
    end

    drain_results();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
